// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked also during reset.
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/ibmw_pkg.sv -----
package ibmw_pkg;

   // Input modes.
   localparam logic [2:0] MODE_MAP_LOAD = 3'd0;
   localparam logic [2:0] MODE_PTR_LOAD = 3'd1;
   localparam logic [2:0] MODE_SIZE     = 3'd2;
   localparam logic [2:0] MODE_REQUEST  = 3'd3;
   localparam logic [2:0] MODE_REPLY    = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_FETCH = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_HOLE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_BLOCK_SIZE_LOG2   = 2'd0;
   localparam logic [1:0] REG_IMAGE_BLOCK_LOG2  = 2'd1;
   localparam logic [1:0] REG_DATA_OFFSET       = 2'd2;
   localparam logic [1:0] REG_PARTITION_SECTOR  = 2'd3;

   localparam int NUM_INODE_PTRS = 15;
   localparam int NUM_DIRECT     = 12;
   localparam int QUEUE_DEPTH    = 2;

   typedef logic [2:0] op_type;
   localparam op_type OP_MAP_LOAD = 3'd0;
   localparam op_type OP_PTR_LOAD = 3'd1;
   localparam op_type OP_SIZE     = 3'd2;
   localparam op_type OP_REQUEST  = 3'd3;
   localparam op_type OP_REPLY    = 3'd4;

   typedef struct packed {
      op_type      op;
      logic [11:0] slot;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic [4:0]  block_size_log2;
      logic [4:0]  image_block_log2;
      logic [31:0] data_offset;
      logic [31:0] partition_first_sector;
   } cfg_type;

endpackage

// ----- rtl/ibmw_ifs.sv -----
interface ibmw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [11:0] slot;
   logic [31:0] value;
   modport source (output valid, mode, slot, value, input ready);
   modport sink (input valid, mode, slot, value, output ready);
endinterface

interface ibmw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] address;
   logic [16:0] byte_count;
   modport source (output valid, kind, address, byte_count, input ready);
   modport sink (input valid, kind, address, byte_count, output ready);
endinterface

// ----- rtl/ibmw_front.sv -----
module ibmw_front #(
   parameter int MAP_ENTRIES = 4096
) (
   ibmw_req_if.sink          req_chan,
   input  logic              queue_full,
   output logic              push,
   output ibmw_pkg::entry_type push_entry
);
   import ibmw_pkg::*;

   logic keep;

   // Loads with an out-of-range slot and unknown modes are dropped here.
   always_comb begin
      keep = 1'b0;
      push_entry.slot  = req_chan.slot;
      push_entry.value = req_chan.value;
      push_entry.op    = OP_SIZE;
      unique case (req_chan.mode)
         MODE_MAP_LOAD: begin
            push_entry.op = OP_MAP_LOAD;
            keep = 32'(req_chan.slot) < 32'(MAP_ENTRIES);
         end
         MODE_PTR_LOAD: begin
            push_entry.op = OP_PTR_LOAD;
            keep = 32'(req_chan.slot) < 32'(NUM_INODE_PTRS);
         end
         MODE_SIZE: begin
            push_entry.op = OP_SIZE;
            keep = 1'b1;
         end
         MODE_REQUEST: begin
            push_entry.op = OP_REQUEST;
            keep = 1'b1;
         end
         MODE_REPLY: begin
            push_entry.op = OP_REPLY;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full && keep;

endmodule

// ----- rtl/ibmw_queue.sv -----
module ibmw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ibmw_pkg::entry_type push_entry,
   output logic                full,
   output logic                pop_valid,
   output ibmw_pkg::entry_type pop_entry,
   input  logic                pop
);
   import ibmw_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop && pop_valid) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !(pop && pop_valid)) begin
         count_in = count_ff + CW'(1);
      end else if (!push && pop && pop_valid) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/ibmw_back.sv -----
module ibmw_back #(
   parameter int MAP_ENTRIES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  ibmw_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   input  ibmw_pkg::entry_type pop_entry,
   output logic                pop,
   ibmw_rsp_if.source          rsp_chan
);
   import ibmw_pkg::*;

   localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_XLATE  = 2'd2;
   localparam logic [1:0] S_MAP    = 2'd3;

   logic [31:0] map_mem [MAP_ENTRIES];
   logic [31:0] map_rd_ff;
   logic        map_we, map_re;
   logic [AW-1:0] map_raddr;

   logic [31:0] inode_ff [NUM_INODE_PTRS];
   logic [31:0] file_size_ff;
   logic [1:0]  state_ff, state_in;
   logic [1:0]  level_ff, level_in;
   logic [1:0]  next_level_ff, next_level_in;
   logic        to_data_ff, to_data_in;
   logic [13:0] dbl_ff, dbl_in, sgl_ff, sgl_in;
   logic [16:0] pend_ff, pend_in;
   logic [31:0] bn_ff, pos_ff, pos_in, off_ff, off_in;

   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [31:0] out_addr_ff;
   logic [16:0] out_count_ff;
   logic        emit;
   logic [1:0]  emit_kind;
   logic [31:0] emit_addr;
   logic [16:0] emit_count;
   logic        out_free;

   logic [4:0]  bl, il;
   logic [3:0]  s;
   logic [47:0] start;
   logic        past_end;
   logic [31:0] diff;
   logic [16:0] bsz, pend_new;
   logic [42:0] n1, n2, n3, r1, r2, r3;
   logic [13:0] mask;
   logic [31:0] a, blk, off, word_pos;
   logic [3:0]  ptr_sel;
   logic [31:0] ptr;

   function automatic logic [31:0] pos_calc(logic [31:0] base, logic [13:0] idx,
                                            logic [4:0] shift);
      pos_calc = (base << shift) + {16'd0, idx, 2'b00};
   endfunction

   always_comb begin
      bl = (cfg.block_size_log2 < 5'd10) ? 5'd10 :
           (cfg.block_size_log2 > 5'd16) ? 5'd16 : cfg.block_size_log2;
      il = (cfg.image_block_log2 < 5'd9) ? 5'd9 :
           (cfg.image_block_log2 > 5'd30) ? 5'd30 : cfg.image_block_log2;
      s  = 4'(bl - 5'd2);
   end

   // Request decode: file end check and index split.
   always_comb begin
      start    = {16'd0, bn_ff} << bl;
      past_end = start >= {16'd0, file_size_ff};
      diff     = file_size_ff - start[31:0];
      bsz      = 17'd1 << bl;
      pend_new = (diff >= {15'd0, bsz}) ? bsz : diff[16:0];
      n1       = 43'd1 << s;
      n2       = 43'd1 << {s, 1'b0};
      n3       = 43'd1 << (6'(s) * 6'd3);
      mask     = 14'(n1 - 43'd1);
      r1       = {11'd0, bn_ff} - 43'd12;
      r2       = r1 - n1;
      r3       = r2 - n2;
      if (bn_ff < 32'(NUM_DIRECT)) begin
         ptr_sel = bn_ff[3:0];
      end else if (r1 < n1) begin
         ptr_sel = 4'd12;
      end else if (r2 < n2) begin
         ptr_sel = 4'd13;
      end else begin
         ptr_sel = 4'd14;
      end
      ptr = inode_ff[ptr_sel];
   end

   // Translation of a file system byte position into the image.
   always_comb begin
      a   = {cfg.partition_first_sector[22:0], 9'd0} + pos_ff;
      blk = a >> il;
      off = a & ((32'd1 << il) - 32'd1);
   end

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      next_level_in = next_level_ff;
      to_data_in    = to_data_ff;
      dbl_in        = dbl_ff;
      sgl_in        = sgl_ff;
      pend_in       = pend_ff;
      pos_in        = pos_ff;
      off_in        = off_ff;
      pop           = 1'b0;
      map_we        = 1'b0;
      map_re        = 1'b0;
      map_raddr     = blk[AW-1:0];
      emit          = 1'b0;
      emit_kind     = KIND_ERROR;
      emit_addr     = '0;
      emit_count    = '0;
      word_pos      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && (out_free || pop_entry.op != OP_REPLY)) begin
               pop = 1'b1;
               case (pop_entry.op)
                  OP_MAP_LOAD: map_we = 1'b1;
                  OP_REQUEST: begin
                     level_in = 2'd0;
                     state_in = S_DECODE;
                  end
                  OP_REPLY: begin
                     if (level_ff == 2'd1) begin
                        pos_in     = pos_calc(pop_entry.value, 14'd0, bl);
                        to_data_in = 1'b1;
                        state_in   = S_XLATE;
                     end else if (level_ff != 2'd0) begin
                        if (pop_entry.value == '0) begin
                           emit       = 1'b1;
                           emit_kind  = KIND_HOLE;
                           emit_count = pend_ff;
                           level_in   = 2'd0;
                        end else begin
                           word_pos = pos_calc(pop_entry.value,
                                               (level_ff == 2'd3) ? dbl_ff : sgl_ff, bl);
                           pos_in        = word_pos;
                           next_level_in = level_ff - 2'd1;
                           to_data_in    = 1'b0;
                           state_in      = S_XLATE;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DECODE: begin
            if (out_free) begin
               state_in = S_XLATE;
               if (past_end) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  pend_in = pend_new;
                  if (bn_ff < 32'(NUM_DIRECT)) begin
                     pos_in     = pos_calc(ptr, 14'd0, bl);
                     to_data_in = 1'b1;
                  end else if (r1 < n1) begin
                     pos_in        = pos_calc(ptr, 14'(r1), bl);
                     next_level_in = 2'd1;
                     to_data_in    = 1'b0;
                  end else if (r2 < n2) begin
                     sgl_in        = 14'(r2) & mask;
                     pos_in        = pos_calc(ptr, 14'(r2 >> s), bl);
                     next_level_in = 2'd2;
                     to_data_in    = 1'b0;
                  end else if (r3 < n3) begin
                     dbl_in        = 14'(r3 >> s) & mask;
                     sgl_in        = 14'(r3) & mask;
                     pos_in        = pos_calc(ptr, 14'(r3 >> {s, 1'b0}), bl);
                     next_level_in = 2'd3;
                     to_data_in    = 1'b0;
                  end else begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
                  // An empty indirect pointer in the inode is a hole.
                  if (bn_ff >= 32'(NUM_DIRECT) && (r1 < n1 || r2 < n2 || r3 < n3) &&
                      ptr == '0) begin
                     emit       = 1'b1;
                     emit_kind  = KIND_HOLE;
                     emit_count = pend_new;
                     state_in   = S_IDLE;
                  end
               end
            end
         end
         S_XLATE: begin
            if (blk >= 32'(MAP_ENTRIES)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  level_in = 2'd0;
                  state_in = S_IDLE;
               end
            end else begin
               map_re   = 1'b1;
               off_in   = off;
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = to_data_ff ? KIND_DATA : KIND_FETCH;
               emit_addr  = cfg.data_offset + ((map_rd_ff << il) | off_ff);
               emit_count = to_data_ff ? pend_ff : 17'd0;
               level_in   = to_data_ff ? 2'd0 : next_level_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         file_size_ff <= '0;
         dbl_ff       <= '0;
         sgl_ff       <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         dbl_ff   <= dbl_in;
         sgl_ff   <= sgl_in;
         pend_ff  <= pend_in;
         if (pop && pop_entry.op == OP_SIZE) begin
            file_size_ff <= pop_entry.value;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      next_level_ff <= next_level_in;
      to_data_ff    <= to_data_in;
      pos_ff        <= pos_in;
      off_ff        <= off_in;
      if (pop && pop_entry.op == OP_REQUEST) begin
         bn_ff <= pop_entry.value;
      end
      if (pop && pop_entry.op == OP_PTR_LOAD) begin
         inode_ff[pop_entry.slot[3:0]] <= pop_entry.value;
      end
      if (emit) begin
         out_kind_ff  <= emit_kind;
         out_addr_ff  <= emit_addr;
         out_count_ff <= emit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[AW'(pop_entry.slot)] <= pop_entry.value;
      end
      if (map_re) begin
         map_rd_ff <= map_mem[map_raddr];
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_kind_ff;
   assign rsp_chan.address    = out_addr_ff;
   assign rsp_chan.byte_count = out_count_ff;

endmodule

// ----- rtl/indirect_block_map_walker.sv -----
// Channel   Direction  Words
// req_chan  in         mode, slot, value
// rsp_chan  out        kind, address, byte_count
//
// Loads are stored in the back end as they are popped. A request steps through pop,
// decode, image block number with registered map read, and address add; a hole or
// error ends it at decode, or at the map read when the block is off the map. A pointer
// reply skips decode; a zero word from a double or triple indirect block is a hole at pop.
// Reset is synchronous; the map and inode pointers hold garbage until loaded.
// A two-word queue lets the input side run ahead while a result waits.
module indirect_block_map_walker #(
   parameter int MAP_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   ibmw_req_if.sink    req_chan,
   ibmw_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import ibmw_pkg::*;

   cfg_type   cfg_ff;
   logic      push, queue_full, pop_valid, pop;
   entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size_log2        <= 5'd10;
         cfg_ff.image_block_log2       <= 5'd20;
         cfg_ff.data_offset            <= '0;
         cfg_ff.partition_first_sector <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_BLOCK_SIZE_LOG2:  cfg_ff.block_size_log2  <= csr_write_data[4:0];
            REG_IMAGE_BLOCK_LOG2: cfg_ff.image_block_log2 <= csr_write_data[4:0];
            REG_DATA_OFFSET:      cfg_ff.data_offset      <= csr_write_data;
            REG_PARTITION_SECTOR: cfg_ff.partition_first_sector <= csr_write_data;
            default: ;
         endcase
      end
   end

   ibmw_front #(.MAP_ENTRIES(MAP_ENTRIES)) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ibmw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   ibmw_back #(.MAP_ENTRIES(MAP_ENTRIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- rtl/ibmw_checker.sv -----
`include "assert_macros.svh"

module ibmw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_address,
   input logic [16:0] rsp_byte_count
);
   import ibmw_pkg::*;

   // A word offered but not taken is still offered next cycle.
   `ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready, rsp_valid || reset)
   `ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid)
   `ASSERT_IMPLY(a_no_count, clock, reset, rsp_valid && (rsp_kind == KIND_FETCH || rsp_kind == KIND_ERROR), rsp_byte_count == 17'd0)
   `ASSERT_IMPLY(a_no_addr, clock, reset, rsp_valid && (rsp_kind == KIND_HOLE || rsp_kind == KIND_ERROR), rsp_address == 32'd0)

endmodule

bind indirect_block_map_walker ibmw_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_address    (rsp_chan.address),
   .rsp_byte_count (rsp_chan.byte_count)
);

// ----- verif/tb.sv -----
module tb;
   import ibmw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [16:0] byte_count;
   } walk_result_type;

   localparam int MAP_SIZE = 4096;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PRELOAD_ENTRIES = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = REG_BLOCK_SIZE_LOG2;
   logic [31:0] csr_write_data = '0;

   ibmw_req_if req_chan ();
   ibmw_rsp_if rsp_chan ();

   indirect_block_map_walker #(.MAP_ENTRIES(MAP_SIZE)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the walker: registers, stores and walk state.
   logic [4:0]   fs_log2_reg = 5'd10;
   logic [4:0]   img_log2_reg = 5'd20;
   logic [31:0]  data_base = '0;
   logic [31:0]  part_sector = '0;
   logic [31:0]  image_map [MAP_SIZE];
   bit           map_loaded [MAP_SIZE];
   logic [31:0]  inode_ptr [NUM_INODE_PTRS];
   logic [31:0]  file_size = '0;
   logic [1:0]   walk_level = '0;
   logic [13:0]  dbl_idx = '0;
   logic [13:0]  sgl_idx = '0;
   logic [16:0]  pending_count = '0;
   bit           unloaded_read;

   walk_result_type expected_results [$];
   bit           steady = 1'b0;
   int           hold_cycles = 0;
   int           failures = 0;
   int           words_sent = 0;
   int           results_seen = 0;
   int           settings_run = 1;
   int           cycles = 0;

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int fs_shift();
      if (fs_log2_reg < 10) return 10;
      if (fs_log2_reg > 16) return 16;
      return fs_log2_reg;
   endfunction

   function automatic int img_shift();
      if (img_log2_reg < 9) return 9;
      if (img_log2_reg > 30) return 30;
      return img_log2_reg;
   endfunction

   function automatic walk_result_type make_result(logic [1:0] kind, logic [31:0] addr,
                                                   logic [16:0] count);
      walk_result_type r;
      r.kind = kind;
      r.address = addr;
      r.byte_count = count;
      return r;
   endfunction

   // File system byte position to image byte address; zero if off the map.
   function automatic bit map_translate(input logic [31:0] pos, output logic [31:0] addr);
      int il;
      logic [31:0] a, blk, off;
      il = img_shift();
      a = part_sector * 32'd512 + pos;
      blk = a >> il;
      off = a & ((32'd1 << il) - 32'd1);
      addr = '0;
      if (blk >= MAP_SIZE) return 1'b0;
      if (!map_loaded[blk]) unloaded_read = 1'b1;
      addr = data_base + (image_map[blk] << il) + off;
      return 1'b1;
   endfunction

   function automatic walk_result_type walk_error();
      walk_level = '0;
      return make_result(KIND_ERROR, '0, '0);
   endfunction

   function automatic walk_result_type walk_hole();
      walk_level = '0;
      return make_result(KIND_HOLE, '0, pending_count);
   endfunction

   function automatic walk_result_type fetch_word(logic [31:0] ptr, logic [31:0] idx,
                                                  logic [1:0] next_level);
      logic [31:0] addr;
      if (!map_translate((ptr << fs_shift()) + (idx << 2), addr)) return walk_error();
      walk_level = next_level;
      return make_result(KIND_FETCH, addr, '0);
   endfunction

   function automatic walk_result_type data_block(logic [31:0] blk);
      logic [31:0] addr;
      if (!map_translate(blk << fs_shift(), addr)) return walk_error();
      walk_level = '0;
      return make_result(KIND_DATA, addr, pending_count);
   endfunction

   function automatic walk_result_type start_request(logic [31:0] bn);
      int bl, s;
      logic [63:0] n, mask, start, diff, remv;
      bl = fs_shift();
      s = bl - 2;
      n = 64'd1 << s;
      mask = n - 64'd1;
      start = {32'd0, bn} << bl;
      walk_level = '0;
      if (start >= {32'd0, file_size}) return walk_error();
      diff = {32'd0, file_size} - start;
      pending_count = (diff >= (64'd1 << bl)) ? 17'(64'd1 << bl) : diff[16:0];
      if (bn < NUM_DIRECT) return data_block(inode_ptr[bn]);
      remv = {32'd0, bn} - NUM_DIRECT;
      if (remv < n) begin
         if (inode_ptr[12] == '0) return walk_hole();
         return fetch_word(inode_ptr[12], remv[31:0], 2'd1);
      end
      remv -= n;
      if (remv < n * n) begin
         sgl_idx = 14'(remv & mask);
         if (inode_ptr[13] == '0) return walk_hole();
         return fetch_word(inode_ptr[13], 32'(remv >> s), 2'd2);
      end
      remv -= n * n;
      if (remv < n * n * n) begin
         dbl_idx = 14'((remv >> s) & mask);
         sgl_idx = 14'(remv & mask);
         if (inode_ptr[14] == '0) return walk_hole();
         return fetch_word(inode_ptr[14], 32'(remv >> (2 * s)), 2'd3);
      end
      return walk_error();
   endfunction

   // Applies one input word to the shadow state; returns 1 if it yields a result.
   function automatic bit walk_predict(input logic [2:0] mode, input logic [11:0] slot,
                                       input logic [31:0] value, output walk_result_type res);
      res = '0;
      case (mode)
         MODE_MAP_LOAD: begin
            image_map[slot] = value;
            map_loaded[slot] = 1'b1;
         end
         MODE_PTR_LOAD: if (slot < NUM_INODE_PTRS) inode_ptr[slot] = value;
         MODE_SIZE: file_size = value;
         MODE_REQUEST: begin
            res = start_request(value);
            return 1'b1;
         end
         MODE_REPLY: begin
            case (walk_level)
               2'd3: res = (value == '0) ? walk_hole() :
                           fetch_word(value, {18'd0, dbl_idx}, 2'd2);
               2'd2: res = (value == '0) ? walk_hole() :
                           fetch_word(value, {18'd0, sgl_idx}, 2'd1);
               2'd1: res = data_block(value);
               default: return 1'b0;
            endcase
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Dry run: would this word read a map entry that was never loaded?
   function automatic bit reads_unloaded(logic [2:0] mode, logic [11:0] slot,
                                         logic [31:0] value);
      logic [1:0]  lvl;
      logic [13:0] d, s;
      logic [16:0] p;
      walk_result_type r;
      if (mode != MODE_REQUEST && mode != MODE_REPLY) return 1'b0;
      lvl = walk_level;
      d = dbl_idx;
      s = sgl_idx;
      p = pending_count;
      unloaded_read = 1'b0;
      void'(walk_predict(mode, slot, value, r));
      walk_level = lvl;
      dbl_idx = d;
      sgl_idx = s;
      pending_count = p;
      return unloaded_read;
   endfunction

   function automatic logic [31:0] skewed_word();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic [31:0] pick_block();
      logic [63:0] n;
      n = 64'd1 << (fs_shift() - 2);
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom_range(0, NUM_DIRECT - 1);
         3, 4: return 32'(NUM_DIRECT + $urandom_range(0, 32'(n - 1)));
         5, 6: return 32'(NUM_DIRECT + n + $urandom_range(0, 32'(n * n - 1)));
         7, 8: return 32'(NUM_DIRECT + n + n * n + skewed_word());
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic [2:0] mode, logic [11:0] slot, logic [31:0] value);
      walk_result_type r;
      if (walk_predict(mode, slot, value, r)) expected_results.push_back(r);
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.slot <= slot;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   // A request far past any file end reads nothing and ends any walk.
   task automatic send_safe(logic [2:0] mode, logic [11:0] slot, logic [31:0] value);
      if (reads_unloaded(mode, slot, value)) send_word(MODE_REQUEST, slot, 32'hFFFF_FFFF);
      else send_word(mode, slot, value);
   endtask

   task automatic random_reply();
      logic [31:0] w;
      for (int t = 0; t < 30; t++) begin
         w = ($urandom_range(0, 7) == 0) ? '0 : skewed_word();
         if (!reads_unloaded(MODE_REPLY, 12'($urandom), w)) begin
            send_word(MODE_REPLY, 12'($urandom), w);
            return;
         end
      end
      if (walk_level >= 2'd2) send_word(MODE_REPLY, 12'($urandom), '0);
      else send_word(MODE_REQUEST, 12'($urandom), 32'hFFFF_FFFF);
   endtask

   task automatic walk_to_end(logic [31:0] bn);
      send_safe(MODE_REQUEST, 12'($urandom), bn);
      while (walk_level != '0) random_reply();
   endtask

   task automatic random_step();
      int p;
      logic [2:0] m;
      logic [31:0] v;
      if (walk_level != '0 && $urandom_range(0, 99) < 85) begin
         random_reply();
         return;
      end
      for (int t = 0; t < 30; t++) begin
         p = $urandom_range(0, 99);
         if (p < 8) begin
            m = MODE_MAP_LOAD;
            v = $urandom;
         end else if (p < 12) begin
            m = MODE_PTR_LOAD;
            v = skewed_word();
         end else if (p < 15) begin
            m = MODE_SIZE;
            v = ($urandom_range(0, 9) < 7) ? 32'hFFFF_FFFF : $urandom;
         end else if (p < 18) begin
            m = 3'($urandom_range(4, 7));
            v = $urandom;
         end else begin
            m = MODE_REQUEST;
            v = pick_block();
         end
         if (m == MODE_PTR_LOAD) begin
            send_word(m, 12'($urandom_range(0, NUM_INODE_PTRS)), v);
            return;
         end
         if (!reads_unloaded(m, 12'($urandom), v)) begin
            send_word(m, 12'($urandom), v);
            return;
         end
      end
      send_word(MODE_REQUEST, 12'($urandom), 32'hFFFF_FFFF);
   endtask

   task automatic quiet_until_drained();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_BLOCK_SIZE_LOG2: fs_log2_reg = data[4:0];
         REG_IMAGE_BLOCK_LOG2: img_log2_reg = data[4:0];
         REG_DATA_OFFSET: data_base = data;
         default: part_sector = data;
      endcase
   endtask

   task automatic test_directed();
      for (int i = 0; i < PRELOAD_ENTRIES; i++) send_word(MODE_MAP_LOAD, 12'(i), $urandom);
      for (int i = 0; i < NUM_DIRECT; i++)
         send_word(MODE_PTR_LOAD, 12'(i), $urandom_range(0, 200));
      for (int i = NUM_DIRECT; i < NUM_INODE_PTRS; i++)
         send_word(MODE_PTR_LOAD, 12'(i), $urandom_range(1, 200));
      // Out-of-range pointer slots, unused modes and a stray reply are all ignored.
      send_word(MODE_PTR_LOAD, 12'd15, '1);
      send_word(MODE_PTR_LOAD, 12'hFFF, '1);
      send_word(3'd5, 12'hFFF, '1);
      send_word(3'd7, '0, '0);
      send_word(MODE_REPLY, 12'hABC, 32'h1234_5678);
      send_word(MODE_SIZE, '0, 32'hFFFF_FFFF);
      walk_to_end(32'd0);
      walk_to_end(32'd11);
      walk_to_end(32'd12);
      walk_to_end(32'd12 + 32'd255);
      walk_to_end(32'd12 + 32'd256);
      walk_to_end(32'd12 + 32'd256 + 32'd65536);
      // A zero word from the triple indirect block leaves a hole.
      send_safe(MODE_REQUEST, '0, 32'd12 + 32'd256 + 32'd65536 + 32'd5);
      if (walk_level == 2'd3) send_word(MODE_REPLY, '0, '0);
      // A new request drops a walk already under way.
      send_safe(MODE_REQUEST, '0, 32'd300);
      walk_to_end(32'd3);
      send_word(MODE_PTR_LOAD, 12'd13, '0);
      walk_to_end(32'd400);
      send_word(MODE_PTR_LOAD, 12'd13, 32'd77);
      // Short file: partial last block, then one block past the end.
      send_word(MODE_SIZE, '0, 32'd3000);
      walk_to_end(32'd2);
      walk_to_end(32'd3);
      send_word(MODE_SIZE, '0, 32'hFFFF_FFFF);
   endtask

   task automatic test_default_walks();
      repeat (60) random_step();
   endtask

   task automatic test_register_sweep();
      logic [4:0]  fs_set [5] = '{5'd10, 5'd16, 5'd0, 5'd31, 5'd13};
      logic [4:0]  img_set [5] = '{5'd9, 5'd30, 5'd31, 5'd0, 5'd20};
      logic [31:0] base_set [5];
      logic [31:0] sector_set [5];
      base_set = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom, 32'd0};
      sector_set = '{32'd0, 32'd0, 32'hFFFF_FFFF, $urandom_range(0, 8), 32'd0};
      for (int k = 0; k < 5; k++) begin
         quiet_until_drained();
         set_reg(REG_BLOCK_SIZE_LOG2, ($urandom & ~32'd31) | fs_set[k]);
         set_reg(REG_IMAGE_BLOCK_LOG2, ($urandom & ~32'd31) | img_set[k]);
         set_reg(REG_DATA_OFFSET, base_set[k]);
         set_reg(REG_PARTITION_SECTOR, sector_set[k]);
         settings_run++;
         repeat (40) random_step();
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (40) random_step();
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      repeat (60) random_step();
      steady = 1'b0;
   endtask

   // Result checker and receiver-side stalls.
   initial begin
      walk_result_type exp;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d address %h", rsp_chan.kind,
                      rsp_chan.address);
               failures++;
            end else begin
               exp = expected_results.pop_front();
               if (rsp_chan.kind !== exp.kind) begin
                  $error("kind: expected %0d, got %0d", exp.kind, rsp_chan.kind);
                  failures++;
               end
               if (rsp_chan.address !== exp.address) begin
                  $error("address: expected %h, got %h", exp.address, rsp_chan.address);
                  failures++;
               end
               if (rsp_chan.byte_count !== exp.byte_count) begin
                  $error("byte_count: expected %0d, got %0d", exp.byte_count,
                         rsp_chan.byte_count);
                  failures++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 32);
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_MAP_LOAD;
      req_chan.slot = '0;
      req_chan.value = '0;
      for (int i = 0; i < MAP_SIZE; i++) map_loaded[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_default_walks();
      quiet_until_drained();
      test_backpressure();
      test_register_sweep();
      test_steady_stream();
      quiet_until_drained();
      $display("Sent %0d words and checked %0d results over %0d register settings,",
               words_sent, results_seen, settings_run);
      $display("including direct, indirect, hole, error and stalled-output cases.");
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
